### rtl/fcs_pkg.sv
// Shared types, command codes and constants of the flash command sequencer.
package fcs_pkg;

  localparam int SECTOR_BYTES = 16384;   // power of two, 4096..65536
  localparam int FLASH_BYTES  = 131072;

  localparam int PAGE_W  = 5;
  localparam int OFFS_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = PAGE_W + OFFS_W;
  localparam int ELEN_W  = 18;
  localparam int CMP_W   = 11;
  localparam int ACT_W   = 2;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 48;
  localparam int IN_PAD  = IN_W - (PAGE_W + OFFS_W + BYTE_W);
  localparam int OUT_PAD = OUT_W - (ACT_W + ADDR_W + BYTE_W + ELEN_W);

  localparam logic [CMP_W-1:0]  ADDR_UNLOCK1 = CMP_W'(12'h555);
  localparam logic [CMP_W-1:0]  ADDR_UNLOCK2 = CMP_W'(12'h2AA);
  localparam logic [BYTE_W-1:0] CMD_UNLOCK1  = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_UNLOCK2  = 8'h55;
  localparam logic [BYTE_W-1:0] CMD_PROGRAM  = 8'hA0;
  localparam logic [BYTE_W-1:0] CMD_ERASE    = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_CHIP     = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_SECTOR   = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_RESET    = 8'h0F;

  localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'(SECTOR_BYTES - 1);
  localparam logic [ELEN_W-1:0] SECTOR_LEN  = ELEN_W'(SECTOR_BYTES);
  localparam logic [ELEN_W-1:0] FLASH_LEN   = ELEN_W'(FLASH_BYTES);

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 2'd0,
    ACT_PROGRAM = 2'd1,
    ACT_SECTOR  = 2'd2,
    ACT_CHIP    = 2'd3
  } fcs_action_t;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_SAW_AA     = 7'b0000010,
    PH_UNLOCKED   = 7'b0000100,
    PH_ERASE_SET  = 7'b0001000,
    PH_ERASE_AA   = 7'b0010000,
    PH_ERASE_UNLK = 7'b0100000,
    PH_PROG_ARMED = 7'b1000000
  } fcs_phase_t;

  // Packed so that the last field (page_number) sits in the low bits of tdata.
  typedef struct packed {
    logic [IN_PAD-1:0] pad;
    logic [BYTE_W-1:0] data_byte;
    logic [OFFS_W-1:0] offset;
    logic [PAGE_W-1:0] page_number;
  } fcs_item_t;

  typedef struct packed {
    logic [OUT_PAD-1:0] pad;
    logic [ELEN_W-1:0]  erase_length;
    logic [BYTE_W-1:0]  program_data;
    logic [ADDR_W-1:0]  target_address;
    fcs_action_t        action;
  } fcs_result_t;

endpackage

### rtl/fcs_decode.sv
// Command decode: next sequencer phase and the memory action for one write.
module fcs_decode
  import fcs_pkg::*;
(
  input  fcs_phase_t  phase,
  input  fcs_item_t   item,
  output fcs_phase_t  phase_nxt,
  output fcs_result_t result
);

  logic [CMP_W-1:0]  low;
  logic [ADDR_W-1:0] byte_addr;
  logic              at_u1;
  logic              at_u2;

  assign low       = item.offset[CMP_W-1:0];
  assign byte_addr = {item.page_number, item.offset};
  assign at_u1     = (low == ADDR_UNLOCK1);
  assign at_u2     = (low == ADDR_UNLOCK2);

  always_comb begin
    fcs_phase_t ph;
    ph     = phase;
    result = '0;
    unique case (phase)
      PH_IDLE: begin
        if (at_u1 && item.data_byte == CMD_UNLOCK1) ph = PH_SAW_AA;
      end
      PH_SAW_AA: begin
        if (at_u2 && item.data_byte == CMD_UNLOCK2) ph = PH_UNLOCKED;
      end
      PH_UNLOCKED: begin
        if (at_u1) begin
          if (item.data_byte == CMD_PROGRAM)    ph = PH_PROG_ARMED;
          else if (item.data_byte == CMD_ERASE) ph = PH_ERASE_SET;
          else                                  ph = PH_IDLE;
        end
      end
      PH_ERASE_SET: begin
        if (at_u1 && item.data_byte == CMD_UNLOCK1) ph = PH_ERASE_AA;
      end
      PH_ERASE_AA: begin
        if (at_u2 && item.data_byte == CMD_UNLOCK2) ph = PH_ERASE_UNLK;
      end
      PH_ERASE_UNLK: begin
        if (at_u1 && item.data_byte == CMD_CHIP) begin
          result.action       = ACT_CHIP;
          result.erase_length = FLASH_LEN;
          ph                  = PH_IDLE;
        end else if (item.data_byte == CMD_SECTOR) begin
          result.action         = ACT_SECTOR;
          result.target_address = byte_addr & ~SECTOR_MASK;
          result.erase_length   = SECTOR_LEN;
          ph                    = PH_IDLE;
        end
      end
      PH_PROG_ARMED: begin
        result.action         = ACT_PROGRAM;
        result.target_address = byte_addr;
        result.program_data   = item.data_byte;
        ph                    = PH_IDLE;
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase
    // Reset aborts a sequence, an armed program excepted; idle ignores it.
    if (phase != PH_IDLE && item.data_byte == CMD_RESET) ph = PH_IDLE;
    phase_nxt = ph;
  end

endmodule

### rtl/flash_command_sequencer_core.sv
// Top level of the flash command sequencer: stream ports, pipeline and phase register.
//
// Usage:
//   Each bus write to the flash window enters on the in_ stream as one item
//   (page, offset, data). The block tracks the standard two-write unlock
//   sequence and returns exactly one item per write on the out_ stream,
//   naming the memory action: none, program a byte, sector erase or chip
//   erase, with the target address, program byte and erase length.
//   Path: an accepted write waits in the input register and moves into the result
//   register when that register is free or drains; out_ presents it from there.
//   Throughput: one item per cycle while out_tready stays high, set by the
//   combinational phase update between the input register and the result register.
//   Reset (rst_n low, synchronous): both stages empty, phase returns to idle.
//   Stall: while out_tready is low the result register holds its item; the
//   input register takes one more write if empty, then in_tready drops until
//   the result moves on. Nothing is lost or repeated.
module flash_command_sequencer_core
  import fcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // page_number[4:0], offset[16:5], data_byte[24:17]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // action[1:0], target_address[18:2],
                                       // program_data[26:19], erase_length[44:27]
);

  fcs_item_t   item_r;
  logic        item_vld_r;
  fcs_result_t res_r;
  logic        res_vld_r;
  fcs_phase_t  phase_r;
  fcs_phase_t  phase_nxt;
  fcs_result_t res_nxt;
  logic        advance;

  // Move the input stage forward when the result register is free or drains.
  assign advance   = !res_vld_r || out_tready;
  assign in_tready = !item_vld_r || advance;

  fcs_decode u_decode (
    .phase     (phase_r),
    .item      (item_r),
    .phase_nxt (phase_nxt),
    .result    (res_nxt)
  );

  // Control: stage valids and sequencer phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      phase_r    <= PH_IDLE;
    end else begin
      if (in_tready) item_vld_r <= in_tvalid;
      if (advance) begin
        res_vld_r <= item_vld_r;
        // Commit the phase only when its item leaves for the result stage.
        if (item_vld_r) phase_r <= phase_nxt;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= fcs_item_t'(in_tdata);
    if (advance && item_vld_r)  res_r  <= res_nxt;
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = res_r;

endmodule

### rtl/fcs_checker.sv
// Port-level checks on the flash command sequencer, bound to its top level.
module fcs_checker
  import fcs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Drop output valid after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // No action means an all-zero result.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ACT_NONE |-> out_tdata[OUT_W-1:2] == '0)
    else $error("payload on a no-action result");

  // Program data only on a program result.
  a_pdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ACT_PROGRAM |-> out_tdata[26:19] == '0)
    else $error("program data outside a program result");

  // Chip erase starts at address zero.
  a_chip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ACT_CHIP |-> out_tdata[18:2] == '0)
    else $error("chip erase with nonzero address");

endmodule

bind flash_command_sequencer_core fcs_checker u_fcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
